// File: hdl/cfd_pkg.sv
// Shared types and constants for the command frame decoder.
package cfd_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam int FIELD_BYTES = 6;

    typedef logic [POS_W-1:0] pos_t;

    // Byte positions within a frame
    localparam pos_t POS_OPCODE      = POS_W'(5);
    localparam pos_t POS_FIELD_FIRST = POS_W'(6);
    localparam pos_t POS_FIELD_LAST  = POS_W'(11);
    localparam pos_t POS_SUM_TIME    = POS_W'(10);
    localparam pos_t POS_SUM_INFO    = POS_W'(12);
    localparam pos_t POS_SUM_LAST    = POS_W'(13);
    localparam pos_t POS_CHECK       = POS_W'(14);
    localparam pos_t POS_LAST        = POS_W'(FRAME_BYTES - 1);

    localparam logic [15:0] ASCII_ZERO = 16'd48;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_OPEN      = 3'd1,
        ACT_CLOSE     = 3'd2,
        ACT_TIME      = 3'd3,
        ACT_SCHEDULE  = 3'd4,
        ACT_DISABLE   = 3'd5,
        ACT_CHECK_BAD = 3'd6,
        ACT_UNKNOWN   = 3'd7
    } action_t;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t REG_DEVICE_ID      = 3'd0;
    localparam cfg_index_t REG_OPCODE_OPEN    = 3'd1;
    localparam cfg_index_t REG_OPCODE_CLOSE   = 3'd2;
    localparam cfg_index_t REG_OPCODE_TIME    = 3'd3;
    localparam cfg_index_t REG_OPCODE_INFO    = 3'd4;
    localparam cfg_index_t REG_OPCODE_DISABLE = 3'd5;
    localparam cfg_index_t REG_DISABLED_CODE  = 3'd6;

    localparam logic [7:0] OPCODE_OPEN_RST    = 8'd111;
    localparam logic [7:0] OPCODE_CLOSE_RST   = 8'd99;
    localparam logic [7:0] OPCODE_TIME_RST    = 8'd116;
    localparam logic [7:0] OPCODE_INFO_RST    = 8'd105;
    localparam logic [7:0] OPCODE_DISABLE_RST = 8'd100;

    // Schedule byte order, lowest first
    localparam int SCHED_UP_FREQ   = 2;
    localparam int SCHED_DOWN_FREQ = 5;

    typedef struct packed {
        logic [3:0] fill;
        logic [7:0] down_frequency;
        logic [7:0] down_minute;
        logic [7:0] down_hour;
        logic [7:0] up_frequency;
        logic [7:0] up_minute;
        logic [7:0] up_hour;
        logic [31:0] time_value;
        action_t    action;
        logic       addressed;
    } result_t;

endpackage

// File: hdl/command_frame_decoder.sv
// Command frame decoder: byte stream in, one decoded command per 16-byte frame out.

// Takes one decrypted frame byte per request on s_*, one every clock. Bytes 0-4
// fold into a decimal id compared with device_id, byte 5 is the opcode, bytes
// 6-11 are payload and byte 14 is the check byte. After byte 15 one result
// appears on m_* in the next cycle; other bytes give none. Only the last byte of a
// frame waits while an earlier result is still held and not taken, so the next
// frame streams in while a result waits. Configuration is written through cfg_*
// (always ready); the user must write only while no frame is in progress (unenforced).
module command_frame_decoder
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] addressed, [3:1] action, [35:4] time_value, [43:36] up_hour,
    // [51:44] up_minute, [59:52] up_frequency, [67:60] down_hour,
    // [75:68] down_minute, [83:76] down_frequency, [87:84] zero
    output logic [87:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] device_id_reg;
    logic [7:0]  opcode_open_reg, opcode_close_reg, opcode_time_reg;
    logic [7:0]  opcode_info_reg, opcode_disable_reg, disabled_code_reg;

    pos_t        pos_reg, pos_next;
    logic [15:0] id_reg, id_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  field_reg [FIELD_BYTES];
    logic [7:0]  field_next [FIELD_BYTES];
    logic [7:0]  sum_all_reg, sum_all_next;
    logic [7:0]  sum_time_reg, sum_time_next;
    logic [7:0]  sum_info_reg, sum_info_next;
    logic [7:0]  check_reg, check_next;
    logic [7:0]  sched_reg [FIELD_BYTES];
    logic [7:0]  sched_next [FIELD_BYTES];

    logic        out_valid_reg;
    result_t     out_data_reg, result_next;

    logic        in_accept;
    logic        frame_end;
    logic        addressed;
    action_t     action;
    logic [31:0] time_value;

    assign cfg_ready = 1'b1;
    // only the byte that produces a result needs the result register free
    assign s_tready  = (pos_reg != POS_LAST) || !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign frame_end = in_accept && (pos_reg == POS_LAST);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg      <= '0;
            opcode_open_reg    <= OPCODE_OPEN_RST;
            opcode_close_reg   <= OPCODE_CLOSE_RST;
            opcode_time_reg    <= OPCODE_TIME_RST;
            opcode_info_reg    <= OPCODE_INFO_RST;
            opcode_disable_reg <= OPCODE_DISABLE_RST;
            disabled_code_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEVICE_ID:      device_id_reg      <= cfg_data;
                REG_OPCODE_OPEN:    opcode_open_reg    <= cfg_data[7:0];
                REG_OPCODE_CLOSE:   opcode_close_reg   <= cfg_data[7:0];
                REG_OPCODE_TIME:    opcode_time_reg    <= cfg_data[7:0];
                REG_OPCODE_INFO:    opcode_info_reg    <= cfg_data[7:0];
                REG_OPCODE_DISABLE: opcode_disable_reg <= cfg_data[7:0];
                REG_DISABLED_CODE:  disabled_code_reg  <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // Per-byte state update and end-of-frame decode
    always_comb
    begin
        logic [7:0] b;
        b             = s_tdata;
        pos_next      = pos_reg;
        id_next       = id_reg;
        opcode_next   = opcode_reg;
        sum_all_next  = sum_all_reg;
        sum_time_next = sum_time_reg;
        sum_info_next = sum_info_reg;
        check_next    = check_reg;
        for (int k = 0; k < FIELD_BYTES; k++)
        begin
            field_next[k] = field_reg[k];
            sched_next[k] = sched_reg[k];
        end

        addressed  = (id_reg == device_id_reg);
        action     = ACT_NONE;
        time_value = '0;

        if (in_accept)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg < POS_OPCODE)
            begin
                // acc*10 = acc*8 + acc*2, all mod 2^16
                id_next = (id_reg << 3) + (id_reg << 1) + {8'd0, b} - ASCII_ZERO;
            end
            else if (pos_reg == POS_OPCODE)
            begin
                opcode_next = b;
            end
            else if (pos_reg <= POS_SUM_LAST)
            begin
                for (int k = 0; k < FIELD_BYTES; k++)
                begin
                    if (pos_reg == POS_FIELD_FIRST + POS_W'(k))
                        field_next[k] = b;
                end
                sum_all_next = sum_all_reg + b;
                if (pos_reg >= POS_SUM_TIME)
                    sum_time_next = sum_time_reg + b;
                if (pos_reg >= POS_SUM_INFO)
                    sum_info_next = sum_info_reg + b;
            end
            else if (pos_reg == POS_CHECK)
            begin
                check_next = b;
            end
        end

        if (frame_end)
        begin
            if (addressed)
            begin
                priority if (opcode_reg == opcode_open_reg)
                begin
                    action = (sum_all_reg == check_reg) ? ACT_OPEN : ACT_CHECK_BAD;
                end
                else if (opcode_reg == opcode_close_reg)
                begin
                    action = (sum_all_reg == check_reg) ? ACT_CLOSE : ACT_CHECK_BAD;
                end
                else if (opcode_reg == opcode_time_reg)
                begin
                    if (sum_time_reg == check_reg)
                    begin
                        action     = ACT_TIME;
                        time_value = {field_reg[3], field_reg[2], field_reg[1], field_reg[0]};
                    end
                    else
                    begin
                        action = ACT_CHECK_BAD;
                    end
                end
                else if (opcode_reg == opcode_info_reg)
                begin
                    if (sum_info_reg == check_reg)
                    begin
                        action = ACT_SCHEDULE;
                        for (int k = 0; k < FIELD_BYTES; k++)
                            sched_next[k] = field_reg[k];
                    end
                    else
                    begin
                        action = ACT_CHECK_BAD;
                    end
                end
                else if (opcode_reg == opcode_disable_reg)
                begin
                    if (sum_all_reg == check_reg)
                    begin
                        action = ACT_DISABLE;
                        sched_next[SCHED_UP_FREQ]   = disabled_code_reg;
                        sched_next[SCHED_DOWN_FREQ] = disabled_code_reg;
                    end
                    else
                    begin
                        action = ACT_CHECK_BAD;
                    end
                end
                else
                begin
                    action = ACT_UNKNOWN;
                end
            end

            // new frame
            pos_next      = '0;
            id_next       = '0;
            opcode_next   = '0;
            sum_all_next  = '0;
            sum_time_next = '0;
            sum_info_next = '0;
            check_next    = '0;
            for (int k = 0; k < FIELD_BYTES; k++)
                field_next[k] = '0;
        end

        result_next.fill           = '0;
        result_next.addressed      = addressed;
        result_next.action         = action;
        result_next.time_value     = time_value;
        result_next.up_hour        = sched_next[0];
        result_next.up_minute      = sched_next[1];
        result_next.up_frequency   = sched_next[2];
        result_next.down_hour      = sched_next[3];
        result_next.down_minute    = sched_next[4];
        result_next.down_frequency = sched_next[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            id_reg        <= '0;
            opcode_reg    <= '0;
            sum_all_reg   <= '0;
            sum_time_reg  <= '0;
            sum_info_reg  <= '0;
            check_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < FIELD_BYTES; k++)
            begin
                field_reg[k] <= '0;
                sched_reg[k] <= '0;
            end
        end
        else
        begin
            pos_reg      <= pos_next;
            id_reg       <= id_next;
            opcode_reg   <= opcode_next;
            sum_all_reg  <= sum_all_next;
            sum_time_reg <= sum_time_next;
            sum_info_reg <= sum_info_next;
            check_reg    <= check_next;
            for (int k = 0; k < FIELD_BYTES; k++)
            begin
                field_reg[k] <= field_next[k];
                sched_reg[k] <= sched_next[k];
            end
            if (frame_end)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
            out_data_reg <= result_next;
    end

`ifndef SYNTHESIS
    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (m_tvalid && pos_reg == '0))
        else $error("no result or no restart after the last frame byte");

    a_not_addressed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_data_reg.addressed) |->
            (out_data_reg.action == ACT_NONE && out_data_reg.time_value == '0))
        else $error("result not addressed but carries an action");

    a_time_only_for_set: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_data_reg.action != ACT_TIME) |-> (out_data_reg.time_value == '0))
        else $error("time value given for an action other than set time");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !frame_end)
        else $error("pending result overwritten");
`endif

endmodule

// File: sim/cfd_checker.sv
// Checker for the command frame decoder: predicts each decoded command and compares it.
`timescale 1ns / 1ps

module cfd_checker
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  cfg_index_t  cfg_index,
    input  logic [15:0] cfg_data,
    output int          error_count,
    output int          commands_owed
);

    // Register copies
    logic [15:0] device_id;
    logic [7:0]  op_open, op_close, op_time, op_info, op_disable, disabled_code;

    // Frame in progress
    pos_t        frame_pos;
    logic [15:0] id_fold;
    logic [7:0]  opcode;
    logic [7:0]  payload [FIELD_BYTES];
    logic [7:0]  sum_from_field, sum_from_time, sum_from_info;
    logic [7:0]  check_value;

    logic [7:0]  schedule [FIELD_BYTES];
    result_t     expected_commands [$];
    int          errors = 0;

    task automatic clear_frame();
        frame_pos      = '0;
        id_fold        = '0;
        opcode         = '0;
        sum_from_field = '0;
        sum_from_time  = '0;
        sum_from_info  = '0;
        check_value    = '0;
        for (int i = 0; i < FIELD_BYTES; i++)
            payload[i] = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        result_t cmd;
        if (frame_pos < POS_OPCODE)
            id_fold = id_fold * 16'd10 + {8'd0, b} - ASCII_ZERO;
        else if (frame_pos == POS_OPCODE)
            opcode = b;
        else if (frame_pos <= POS_SUM_LAST)
        begin
            if (frame_pos <= POS_FIELD_LAST)
                payload[3'(frame_pos - POS_FIELD_FIRST)] = b;
            sum_from_field += b;
            if (frame_pos >= POS_SUM_TIME)
                sum_from_time += b;
            if (frame_pos >= POS_SUM_INFO)
                sum_from_info += b;
        end
        else if (frame_pos == POS_CHECK)
            check_value = b;

        if (frame_pos != POS_LAST)
        begin
            frame_pos = frame_pos + 1'b1;
        end
        else
        begin
            cmd = '0;
            cmd.addressed = (id_fold == device_id);
            cmd.action = ACT_NONE;
            // first matching opcode register wins, in register order
            if (cmd.addressed)
            begin
                if (opcode == op_open)
                    cmd.action = (sum_from_field == check_value) ? ACT_OPEN : ACT_CHECK_BAD;
                else if (opcode == op_close)
                    cmd.action = (sum_from_field == check_value) ? ACT_CLOSE : ACT_CHECK_BAD;
                else if (opcode == op_time)
                begin
                    if (sum_from_time == check_value)
                    begin
                        cmd.action = ACT_TIME;
                        cmd.time_value = {payload[3], payload[2], payload[1], payload[0]};
                    end
                    else
                        cmd.action = ACT_CHECK_BAD;
                end
                else if (opcode == op_info)
                begin
                    if (sum_from_info == check_value)
                    begin
                        cmd.action = ACT_SCHEDULE;
                        for (int i = 0; i < FIELD_BYTES; i++)
                            schedule[i] = payload[i];
                    end
                    else
                        cmd.action = ACT_CHECK_BAD;
                end
                else if (opcode == op_disable)
                begin
                    if (sum_from_field == check_value)
                    begin
                        cmd.action = ACT_DISABLE;
                        schedule[SCHED_UP_FREQ]   = disabled_code;
                        schedule[SCHED_DOWN_FREQ] = disabled_code;
                    end
                    else
                        cmd.action = ACT_CHECK_BAD;
                end
                else
                    cmd.action = ACT_UNKNOWN;
            end
            cmd.up_hour        = schedule[0];
            cmd.up_minute      = schedule[1];
            cmd.up_frequency   = schedule[2];
            cmd.down_hour      = schedule[3];
            cmd.down_minute    = schedule[4];
            cmd.down_frequency = schedule[5];
            expected_commands.push_back(cmd);
            clear_frame();
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_command(input result_t got);
        result_t want;
        if (expected_commands.size() == 0)
        begin
            errors++;
            $display("%0t: command with none expected, expected nothing, actual %h",
                     $time, got);
        end
        else
        begin
            want = expected_commands.pop_front();
            compare_field("addressed", 32'(want.addressed), 32'(got.addressed));
            compare_field("action", 32'(want.action), 32'(got.action));
            compare_field("time_value", want.time_value, got.time_value);
            compare_field("up_hour", 32'(want.up_hour), 32'(got.up_hour));
            compare_field("up_minute", 32'(want.up_minute), 32'(got.up_minute));
            compare_field("up_frequency", 32'(want.up_frequency), 32'(got.up_frequency));
            compare_field("down_hour", 32'(want.down_hour), 32'(got.down_hour));
            compare_field("down_minute", 32'(want.down_minute), 32'(got.down_minute));
            compare_field("down_frequency", 32'(want.down_frequency),
                          32'(got.down_frequency));
            compare_field("fill", 32'(want.fill), 32'(got.fill));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            device_id     = '0;
            op_open       = OPCODE_OPEN_RST;
            op_close      = OPCODE_CLOSE_RST;
            op_time       = OPCODE_TIME_RST;
            op_info       = OPCODE_INFO_RST;
            op_disable    = OPCODE_DISABLE_RST;
            disabled_code = '0;
            for (int i = 0; i < FIELD_BYTES; i++)
                schedule[i] = '0;
            clear_frame();
            expected_commands.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_command(result_t'(m_tdata));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DEVICE_ID:      device_id     = cfg_data;
                    REG_OPCODE_OPEN:    op_open       = cfg_data[7:0];
                    REG_OPCODE_CLOSE:   op_close      = cfg_data[7:0];
                    REG_OPCODE_TIME:    op_time       = cfg_data[7:0];
                    REG_OPCODE_INFO:    op_info       = cfg_data[7:0];
                    REG_OPCODE_DISABLE: op_disable    = cfg_data[7:0];
                    REG_DISABLED_CODE:  disabled_code = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
        end
        error_count   <= errors;
        commands_owed <= expected_commands.size();
    end

endmodule

// File: sim/tb_command_frame_decoder.sv
// Testbench top for the command frame decoder: frame stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_command_frame_decoder;
    import cfd_pkg::*;

    // Frame kinds, indexing the opcode settings
    localparam int KIND_OPEN    = 0;
    localparam int KIND_CLOSE   = 1;
    localparam int KIND_TIME    = 2;
    localparam int KIND_INFO    = 3;
    localparam int KIND_DISABLE = 4;
    localparam int KIND_NOISE   = 5;

    localparam int PHASES           = 3;
    localparam int FRAMES_PER_PHASE = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = REG_DEVICE_ID;
    logic [15:0] cfg_data = '0;

    int error_count;
    int commands_owed;
    int hold_off_request = 0;
    int burst_left = 0;
    bit sender_gaps = 1'b1;

    // What the stimulus currently believes is programmed, to build valid frames
    logic [15:0] id_setting;
    logic [7:0]  opcode_setting [5];
    logic [7:0]  disabled_setting;
    logic [7:0]  frame [FRAME_BYTES];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    command_frame_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cfd_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .commands_owed (commands_owed)
    );

    initial
    begin
        #4_000_000;
        $display("FAIL command_frame_decoder");
        $finish;
    end

    // Receiver: changes its readiness mix every so often; a hold-off request
    // forces a long stall counted here
    initial
    begin : receiver
        int mode_left;
        int ready_pct;
        int hold_left;
        mode_left = 0;
        ready_pct = 100;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request > 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(5, 60);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 50;
                    2:       ready_pct = 85;
                    default: ready_pct = 20;
                endcase
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(frame[i]);
    endtask

    // Stop offering and wait until every command has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (commands_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_settings();
        drain();
        write_reg(REG_DEVICE_ID, id_setting);
        write_reg(REG_OPCODE_OPEN, {8'd0, opcode_setting[KIND_OPEN]});
        write_reg(REG_OPCODE_CLOSE, {8'd0, opcode_setting[KIND_CLOSE]});
        write_reg(REG_OPCODE_TIME, {8'd0, opcode_setting[KIND_TIME]});
        write_reg(REG_OPCODE_INFO, {8'd0, opcode_setting[KIND_INFO]});
        write_reg(REG_OPCODE_DISABLE, {8'd0, opcode_setting[KIND_DISABLE]});
        write_reg(REG_DISABLED_CODE, {8'd0, disabled_setting});
        cfg_valid <= 1'b0;
    endtask

    // Recompute the check byte over the span this kind of command covers
    task automatic seal_frame(input int kind, input bit check_good);
        int          first;
        logic [7:0]  check_sum;
        first = (kind == KIND_TIME) ? int'(POS_SUM_TIME) :
                (kind == KIND_INFO) ? int'(POS_SUM_INFO) : int'(POS_FIELD_FIRST);
        check_sum = '0;
        for (int i = first; i <= int'(POS_SUM_LAST); i++)
            check_sum += frame[i];
        frame[POS_CHECK] = check_good ? check_sum : check_sum + 8'($urandom_range(1, 255));
    endtask

    task automatic build_frame(input int kind, input bit id_match, input bit check_good);
        int id_value;
        for (int i = 0; i < FRAME_BYTES; i++)
            frame[i] = 8'($urandom_range(0, 255));
        if (id_match || $urandom_range(0, 1) == 1)
        begin
            id_value = id_match ? int'(id_setting) : $urandom_range(0, 99999);
            // same id reached through the 16-bit wrap
            if (id_match && id_value < 34464 && $urandom_range(0, 3) == 0)
                id_value += 65536;
            for (int i = 4; i >= 0; i--)
            begin
                frame[i] = 8'(ASCII_ZERO) + 8'(id_value % 10);
                id_value = id_value / 10;
            end
        end
        if (kind != KIND_NOISE)
            frame[POS_OPCODE] = opcode_setting[kind];
        seal_frame(kind, check_good);
    endtask

    task automatic random_frame();
        int kind;
        if ($urandom_range(0, 99) < 75)
        begin
            kind = $urandom_range(KIND_OPEN, KIND_DISABLE);
            build_frame(kind, 1'b1, $urandom_range(0, 99) < 85);
        end
        else
        begin
            kind = $urandom_range(KIND_OPEN, KIND_NOISE);
            build_frame(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        send_frame();
    endtask

    initial
    begin : stimulus
        logic [7:0] op_a, op_b;
        id_setting = '0;
        opcode_setting[KIND_OPEN]    = OPCODE_OPEN_RST;
        opcode_setting[KIND_CLOSE]   = OPCODE_CLOSE_RST;
        opcode_setting[KIND_TIME]    = OPCODE_TIME_RST;
        opcode_setting[KIND_INFO]    = OPCODE_INFO_RST;
        opcode_setting[KIND_DISABLE] = OPCODE_DISABLE_RST;
        disabled_setting = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: each command, bad checks, foreign and odd ids
        for (int k = KIND_OPEN; k <= KIND_DISABLE; k++)
        begin
            build_frame(k, 1'b1, 1'b1);
            send_frame();
        end
        build_frame(KIND_NOISE, 1'b1, 1'b1);
        frame[POS_OPCODE] = 8'hFF;
        send_frame();
        for (int k = KIND_OPEN; k <= KIND_DISABLE; k++)
        begin
            build_frame(k, 1'b1, 1'b0);
            send_frame();
        end
        build_frame(KIND_OPEN, 1'b0, 1'b1);
        frame[0] = 8'h31;
        send_frame();
        build_frame(KIND_OPEN, 1'b1, 1'b1);
        frame[0] = 8'h00;
        frame[1] = 8'hFF;
        frame[2] = 8'h3A;
        frame[3] = 8'h2F;
        frame[4] = 8'h80;
        send_frame();
        // schedule of all ones, then of all zeros
        build_frame(KIND_INFO, 1'b1, 1'b1);
        for (int i = int'(POS_FIELD_FIRST); i <= int'(POS_SUM_LAST); i++)
            frame[i] = 8'hFF;
        seal_frame(KIND_INFO, 1'b1);
        send_frame();
        build_frame(KIND_INFO, 1'b1, 1'b1);
        for (int i = int'(POS_FIELD_FIRST); i <= int'(POS_SUM_LAST); i++)
            frame[i] = 8'h00;
        seal_frame(KIND_INFO, 1'b1);
        send_frame();

        // Extremes: every opcode register equal, so priority decides
        id_setting = 16'hFFFF;
        for (int k = KIND_OPEN; k <= KIND_DISABLE; k++)
            opcode_setting[k] = 8'hFF;
        disabled_setting = 8'hFF;
        apply_settings();
        for (int k = KIND_OPEN; k <= KIND_NOISE; k++)
        begin
            build_frame(k, 1'b1, 1'b1);
            send_frame();
        end

        id_setting = '0;
        for (int k = KIND_OPEN; k <= KIND_DISABLE; k++)
            opcode_setting[k] = 8'h00;
        disabled_setting = 8'h00;
        apply_settings();
        for (int k = KIND_OPEN; k <= KIND_NOISE; k++)
        begin
            build_frame(k, 1'b1, 1'b1);
            send_frame();
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            id_setting = 16'($urandom_range(0, 65535));
            op_a = 8'($urandom_range(0, 255));
            op_b = 8'($urandom_range(0, 255));
            for (int k = KIND_OPEN; k <= KIND_DISABLE; k++)
            begin
                if (phase % 2 == 0)
                    opcode_setting[k] = 8'($urandom_range(0, 255));
                else
                    opcode_setting[k] = $urandom_range(0, 1) ? op_a : op_b;
            end
            disabled_setting = 8'($urandom_range(0, 255));
            apply_settings();
            sender_gaps = (phase % 3 != 0);
            // long receiver stall while frames keep coming
            if (phase == 1)
                hold_off_request = 200;
            for (int f = 0; f < FRAMES_PER_PHASE; f++)
                random_frame();
        end

        drain();
        repeat (10) @(posedge clk);
        if (error_count == 0 && commands_owed == 0)
            $display("PASS command_frame_decoder");
        else
            $display("FAIL command_frame_decoder");
        $finish;
    end

endmodule
